[sv/aabb_collision_offsets_defines.svh]
// Assertion macros for the box collision block.
`ifndef AABB_COLLISION_OFFSETS_DEFINES_SVH
`define AABB_COLLISION_OFFSETS_DEFINES_SVH
`ifndef SYNTHESIS
// Check a consequence in the same cycle as its trigger.
`define ACO_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aco: assertion failed");
// Check a consequence in the cycle after its trigger.
`define ACO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aco: assertion failed");
`else
`define ACO_ASSERT_SAME(label, ante, cons)
`define ACO_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/aco_pkg.sv]
// Shared types and constants of the box collision block.
package aco_pkg;

    localparam int MAX_BOXES_DEF  = 16;
    localparam int COORD_BITS_DEF = 24;
    localparam int SLOT_W         = 4;
    localparam int PUSH_W         = 27;
    localparam int PUSH_MAX       = 2 ** (PUSH_W - 1) - 1;

    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic write;
        logic load;
        logic step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic pipe_empty;
    } t_stat;

endpackage

[sv/aco_ctrl.sv]
// Request sequencer: accepts requests, walks the table, closes each query.
module aco_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_req_type,
    input  aco_pkg::t_stat i_stat,
    output logic          busy,
    output aco_pkg::t_cmd  o_cmd
);
    import aco_pkg::*;

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start && i_req_type == REQ_QUERY) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy        = 1'b0;
                o_cmd.write = start && i_req_type == REQ_WRITE;
                o_cmd.load  = start && i_req_type == REQ_QUERY;
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd.flush = i_stat.pipe_empty;
            end
            default: busy = 1'b1;
        endcase
    end

endmodule

[sv/aco_datapath.sv]
// Box table, overlap pipeline and result holding register.
module aco_datapath #(
    parameter int MAX_BOXES  = aco_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = aco_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  aco_pkg::t_cmd                       i_cmd,
    input  logic [aco_pkg::SLOT_W-1:0]          i_slot,
    input  logic signed [COORD_BITS-1:0]        i_pos_x,
    input  logic signed [COORD_BITS-1:0]        i_pos_y,
    input  logic signed [COORD_BITS-1:0]        i_pos_z,
    input  logic signed [COORD_BITS-1:0]        i_ext_x,
    input  logic signed [COORD_BITS-1:0]        i_ext_y,
    input  logic signed [COORD_BITS-1:0]        i_ext_z,
    output aco_pkg::t_stat                      o_stat,
    output logic                               o_strobe,
    output logic                               o_hit,
    output logic [aco_pkg::SLOT_W-1:0]          o_hit_slot,
    output logic signed [aco_pkg::PUSH_W-1:0]   o_push_x,
    output logic signed [aco_pkg::PUSH_W-1:0]   o_push_y,
    output logic signed [aco_pkg::PUSH_W-1:0]   o_push_z,
    output logic                               o_last
);
    import aco_pkg::*;

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int SX_W  = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
    localparam int C2_W  = COORD_BITS + 2;   // corner * 2 + extent
    localparam int A_W   = COORD_BITS;       // |extent|
    localparam int D_W   = COORD_BITS + 3;   // center difference
    localparam int S_W   = COORD_BITS + 1;   // extent sum
    localparam int M_W   = COORD_BITS + 4;   // sum - |diff|
    localparam int MAG_W = COORD_BITS + 1;   // positive overlap
    localparam int AX_W  = C2_W + A_W;
    localparam int ENT_W = 3 * AX_W;
    localparam int SAT_W = ((MAG_W > PUSH_W) ? MAG_W : PUSH_W) + 1;

    // request fields as per-axis arrays
    logic signed [COORD_BITS-1:0] in_pos [3];
    logic signed [COORD_BITS-1:0] in_ext [3];
    logic signed [C2_W-1:0]       in_c2  [3];
    logic [A_W-1:0]               in_a   [3];
    logic [ENT_W-1:0]             wr_ent;
    logic [SX_W-1:0]              slot_ext;
    logic                         wr_ok;

    // box table and scan state
    logic [ENT_W-1:0]     mem [MAX_BOXES];
    logic [ENT_W-1:0]     r_rd_ent;
    logic [MAX_BOXES-1:0] r_valid;
    logic [IDX_W-1:0]     r_idx;
    logic                 scan_end;

    // query box
    logic signed [C2_W-1:0] r_q_c2 [3];
    logic [A_W-1:0]         r_q_a  [3];

    // pipeline stages
    logic signed [C2_W-1:0] rd_c2 [3];
    logic [A_W-1:0]         rd_a  [3];
    logic                   r0_vld, r1_vld, r2_vld, r3_vld;
    logic [IDX_W-1:0]       r0_tag, r1_tag, r2_tag, r3_tag;
    logic signed [D_W-1:0]  r1_diff [3];
    logic [S_W-1:0]         r1_sum  [3];
    logic [D_W-1:0]         r2_ad   [3];
    logic [S_W-1:0]         r2_sum  [3];
    logic                   r2_neg  [3];
    logic signed [M_W-1:0]  ovl     [3];
    logic [MAG_W-1:0]       r3_mag  [3];
    logic                   r3_neg  [3];
    logic [2:0]             r3_ok;
    logic                   hit;
    logic [SAT_W-1:0]       mag_w   [3];
    logic signed [PUSH_W-1:0] sat_push [3];

    // pending hit
    logic                     r_hold_vld;
    logic [SLOT_W-1:0]        r_hold_tag;
    logic signed [PUSH_W-1:0] r_hold_push [3];

    // result registers
    logic                     r_strobe;
    logic                     r_hit;
    logic [SLOT_W-1:0]        r_hit_slot;
    logic signed [PUSH_W-1:0] r_push [3];
    logic                     r_last;

    // Convert corner and extent into doubled center and size
    assign in_pos = '{i_pos_x, i_pos_y, i_pos_z};
    assign in_ext = '{i_ext_x, i_ext_y, i_ext_z};

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            in_c2[a] = (C2_W'(in_pos[a]) <<< 1) + C2_W'(in_ext[a]);
            in_a[a]  = in_ext[a][COORD_BITS-1] ? A_W'(-in_ext[a]) : A_W'(in_ext[a]);
        end
    end

    assign wr_ent   = {in_c2[0], in_a[0], in_c2[1], in_a[1], in_c2[2], in_a[2]};
    assign slot_ext = SX_W'(i_slot);
    assign wr_ok    = slot_ext < SX_W'(MAX_BOXES);

    // Write the table and read the slot under scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && wr_ok) begin
            mem[slot_ext[IDX_W-1:0]] <= wr_ent;
        end
        if (i_cmd.step) begin
            r_rd_ent <= mem[r_idx];
        end
    end

    assign scan_end = r_idx == IDX_W'(MAX_BOXES - 1);

    // Track valid slots and the scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_idx   <= '0;
            r0_vld  <= 1'b0;
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
        end else begin
            if (i_cmd.write && wr_ok) begin
                r_valid[slot_ext[IDX_W-1:0]] <= 1'b1;
            end
            if (i_cmd.step) begin
                r_idx <= scan_end ? '0 : r_idx + 1'b1;
            end
            r0_vld <= i_cmd.step && r_valid[r_idx];
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    assign o_stat.scan_end   = scan_end;
    assign o_stat.pipe_empty = !(r0_vld || r1_vld || r2_vld || r3_vld);

    // Latch the query box
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q_c2 <= in_c2;
            r_q_a  <= in_a;
        end
    end

    // Unpack the stored entry
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rd_c2[a] = r_rd_ent[ENT_W-1-a*AX_W -: C2_W];
            rd_a[a]  = r_rd_ent[ENT_W-1-a*AX_W-C2_W -: A_W];
        end
    end

    // Stage one: center difference and size sum
    always_ff @(posedge i_clk) begin
        r0_tag <= r_idx;
        r1_tag <= r0_tag;
        r2_tag <= r1_tag;
        r3_tag <= r2_tag;
        for (int a = 0; a < 3; a++) begin
            r1_diff[a] <= D_W'(r_q_c2[a]) - D_W'(rd_c2[a]);
            r1_sum[a]  <= S_W'(r_q_a[a]) + S_W'(rd_a[a]);
        end
    end

    // Stage two: magnitude and sign of the difference
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r2_neg[a] <= r1_diff[a][D_W-1];
            r2_ad[a]  <= r1_diff[a][D_W-1] ? D_W'(-r1_diff[a]) : D_W'(r1_diff[a]);
            r2_sum[a] <= r1_sum[a];
        end
    end

    // Stage three: overlap depth, strict overlap test
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            ovl[a] = $signed({3'b000, r2_sum[a]}) - $signed({1'b0, r2_ad[a]});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r3_mag[a] <= ovl[a][MAG_W-1:0];
            r3_neg[a] <= r2_neg[a];
            r3_ok[a]  <= !ovl[a][M_W-1] && (ovl[a] != '0);
        end
    end

    assign hit = r3_vld && (&r3_ok);

    // Apply sign and clamp to the push range
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mag_w[a] = SAT_W'(r3_mag[a]);
            if (!r3_neg[a]) begin
                sat_push[a] = (mag_w[a] > SAT_W'(PUSH_MAX)) ? PUSH_W'(PUSH_MAX)
                                                            : PUSH_W'(mag_w[a]);
            end else begin
                sat_push[a] = (mag_w[a] > SAT_W'(PUSH_MAX + 1))
                            ? {1'b1, {(PUSH_W-1){1'b0}}}
                            : PUSH_W'(-mag_w[a]);
            end
        end
    end

    // Hold the latest hit, emit the previous one; close the query on flush
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (hit) begin
                if (r_hold_vld) begin
                    r_strobe   <= 1'b1;
                    r_hit      <= 1'b1;
                    r_hit_slot <= r_hold_tag;
                    r_push     <= r_hold_push;
                    r_last     <= 1'b0;
                end
                r_hold_vld  <= 1'b1;
                r_hold_tag  <= SLOT_W'(r3_tag);
                r_hold_push <= sat_push;
            end else if (i_cmd.flush) begin
                r_strobe   <= 1'b1;
                r_hit      <= r_hold_vld;
                r_hit_slot <= r_hold_vld ? r_hold_tag : '0;
                for (int a = 0; a < 3; a++) begin
                    r_push[a] <= r_hold_vld ? r_hold_push[a] : '0;
                end
                r_last     <= 1'b1;
                r_hold_vld <= 1'b0;
            end
        end
    end

    assign o_strobe   = r_strobe;
    assign o_hit      = r_hit;
    assign o_hit_slot = r_hit_slot;
    assign o_push_x   = r_push[0];
    assign o_push_y   = r_push[1];
    assign o_push_z   = r_push[2];
    assign o_last     = r_last;

endmodule

[sv/aabb_collision_offsets.sv]
// Top level of the box collision block: sequencer plus datapath.
//
// Requests enter on start while busy is low. A write request (i_req_type = 1)
// stores the box given by a corner and signed extent into slot i_slot and
// marks it valid; writes to slots at or past MAX_BOXES are dropped. A query
// request (i_req_type = 0) compares its box with every valid slot in slot
// order and reports one result per box that overlaps on all three axes,
// with push offsets in half-LSB units; a query with no overlap reports a
// single miss. o_last marks the final result of each query.
// Each result shows for exactly one cycle with o_strobe; the receiver cannot
// stall, so nothing is held back for it.
// While a query runs, busy stays high: the sequencer reads the table once per
// slot, waits until the overlap pipeline has emptied, then closes the query.
// The next request can be taken once busy is low again. The last result
// appears in the first cycle with busy low.
// Reset clears all valid bits, the scan index, the pipeline valid flags and
// the sequencer; table contents stay as they are and are not used until written.
`include "aabb_collision_offsets_defines.svh"
module aabb_collision_offsets #(
    parameter int MAX_BOXES  = aco_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = aco_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic                               i_req_type,
    input  logic [aco_pkg::SLOT_W-1:0]          i_slot,
    input  logic signed [COORD_BITS-1:0]        i_pos_x,
    input  logic signed [COORD_BITS-1:0]        i_pos_y,
    input  logic signed [COORD_BITS-1:0]        i_pos_z,
    input  logic signed [COORD_BITS-1:0]        i_ext_x,
    input  logic signed [COORD_BITS-1:0]        i_ext_y,
    input  logic signed [COORD_BITS-1:0]        i_ext_z,
    output logic                               busy,
    output logic                               o_strobe,
    output logic                               o_hit,
    output logic [aco_pkg::SLOT_W-1:0]          o_hit_slot,
    output logic signed [aco_pkg::PUSH_W-1:0]   o_push_x,
    output logic signed [aco_pkg::PUSH_W-1:0]   o_push_y,
    output logic signed [aco_pkg::PUSH_W-1:0]   o_push_z,
    output logic                               o_last
);
    import aco_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequence requests
    aco_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .busy       (busy),
        .o_cmd      (cmd)
    );

    // Store boxes and test overlaps
    aco_datapath #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_slot     (i_slot),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_ext_x    (i_ext_x),
        .i_ext_y    (i_ext_y),
        .i_ext_z    (i_ext_z),
        .o_stat     (stat),
        .o_strobe   (o_strobe),
        .o_hit      (o_hit),
        .o_hit_slot (o_hit_slot),
        .o_push_x   (o_push_x),
        .o_push_y   (o_push_y),
        .o_push_z   (o_push_z),
        .o_last     (o_last)
    );

    // Check result framing
    `ACO_ASSERT_SAME(a_miss_is_last, o_strobe && !o_hit, o_last)
    `ACO_ASSERT_NEXT(a_quiet_after_last, o_strobe && o_last, !o_strobe)
    `ACO_ASSERT_SAME(a_result_from_query, o_strobe, $past(busy))
    `ACO_ASSERT_SAME(a_hit_pushes_nonzero, o_strobe && o_hit, |o_push_x && |o_push_y && |o_push_z)

endmodule
